FILE: rtl/lstm_pkg.sv
// ----------------------------------------------------------------------------
// Latency statistics monitor package
// Shared widths, constants and the per-cell data type.
// ----------------------------------------------------------------------------
`default_nettype none
package lstm_pkg;
   localparam int WorstNDefault = 8;
   localparam int ValW   = 24;
   localparam int TagW   = 32;
   localparam int CountW = 32;
   localparam int MeanW  = 40;
   localparam int M2W    = 64;
   localparam int VarW   = 48;
   localparam int IntW   = 16;
   localparam int RankW  = 3;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef struct packed {
      logic            valid;
      logic [ValW-1:0] value;
      logic [TagW-1:0] tag;
   } entry_type;
endpackage
`default_nettype wire

FILE: rtl/lstm_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one sample or flush item.
// ----------------------------------------------------------------------------
`default_nettype none
interface lstm_req_if;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [lstm_pkg::ValW-1:0] sample_value;
   logic signed [lstm_pkg::TagW-1:0] frame_tag;
   modport source (output valid, kind, sample_value, frame_tag, input ready);
   modport sink   (input valid, kind, sample_value, frame_tag, output ready);
endinterface
`default_nettype wire

FILE: rtl/lstm_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one summary result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface lstm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lstm_pkg::CountW-1:0] sample_count;
   logic [lstm_pkg::ValW-1:0]   mean_value;
   logic [lstm_pkg::VarW-1:0]   variance_value;
   logic [lstm_pkg::ValW-1:0]   min_value;
   logic [lstm_pkg::ValW-1:0]   max_value;
   logic [lstm_pkg::RankW-1:0]  worst_rank;
   logic [lstm_pkg::ValW-1:0]   worst_value;
   logic signed [lstm_pkg::TagW-1:0] worst_frame;
   logic                        last;
   modport source (output valid, sample_count, mean_value, variance_value, min_value,
                   max_value, worst_rank, worst_value, worst_frame, last, input ready);
   modport sink   (input valid, sample_count, mean_value, variance_value, min_value,
                   max_value, worst_rank, worst_value, worst_frame, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/lstm_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the report interval write data.
// ----------------------------------------------------------------------------
`default_nettype none
interface lstm_csr_if;
   logic                      valid;
   logic                      ready;
   logic [lstm_pkg::IntW-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lstm_cell.sv
// ----------------------------------------------------------------------------
// Worst-list cell
// One entry of the descending worst list. On insert, takes the new item or
// the left neighbour's entry; on shift, takes the left neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none
module lstm_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          insert,
   input  wire                          shift,
   input  wire [lstm_pkg::ValW-1:0]     new_value,
   input  wire [lstm_pkg::TagW-1:0]     new_tag,
   input  wire lstm_pkg::entry_type     left_entry,
   input  wire                          left_takes,
   output lstm_pkg::entry_type          entry,
   output logic                         takes
);
   lstm_pkg::entry_type entry_ff, entry_in;
   logic                 beats;

   // list is largest first; a new value goes after equal entries here
   assign beats = !entry_ff.valid || (new_value > entry_ff.value);
   assign takes = beats;

   always_comb begin
      entry_in = entry_ff;
      if (insert && beats) begin
         if (left_takes) begin
            entry_in = left_entry;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.value = new_value;
            entry_in.tag   = new_tag;
         end
      end else if (shift) begin
         entry_in = left_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.value <= entry_in.value;
      entry_ff.tag   <= entry_in.tag;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

FILE: rtl/lstm_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lstm_divider (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] dividend,
   input  wire  [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in    = trial - {1'b0, div_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = busy_ff && !busy_in && !start;
   assign quotient  = quo_in;
   assign remainder = rem_in[31:0];
endmodule
`default_nettype wire

FILE: rtl/latency_stats_topk_monitor.sv
// A sample item is worked on after acceptance in S_MEAN (start the shared 64-step
//   divider for the mean step), S_M2 (divide), S_MUL (the M2 product) and S_ACC
//   (accumulate), so a new sample is taken only after the block is back in S_IDLE.
// A summary run adds the variance division (skipped when n < 2), then emits one result
//   item at a time while the sink is ready. A nonzero interval write runs a division.
// Reset clears all statistics and the worst list valid bits; interval is zero.
// ----------------------------------------------------------------------------
// Latency statistics monitor top level
// Welford mean/M2, min/max and a worst-N list held in a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none
module latency_stats_topk_monitor #(
   parameter int WORST_N = lstm_pkg::WorstNDefault
) (
   input wire         clock,
   input wire         reset,
   lstm_req_if.sink   req,
   lstm_rsp_if.source rsp,
   lstm_csr_if.sink   csr
);
   localparam int IdxW = (WORST_N > 1) ? $clog2(WORST_N) : 1;
   localparam int FillW = $clog2(WORST_N + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CFG, S_MOD, S_MEAN, S_M2, S_MUL, S_ACC, S_VAR, S_EMIT
   } state_type;

   state_type state_ff;

   logic [lstm_pkg::IntW-1:0]   interval_ff;
   logic [lstm_pkg::CountW-1:0] count_ff;
   logic [lstm_pkg::MeanW-1:0]  mean_ff;
   logic [lstm_pkg::M2W-1:0]    m2_ff;
   logic [lstm_pkg::ValW-1:0]   min_ff, max_ff, v_ff;
   logic [lstm_pkg::TagW-1:0]   tag_ff;
   logic [FillW-1:0]            fill_ff;
   logic                        reported_ff, pos_ff;
   logic [lstm_pkg::MeanW-1:0]  mag_ff, mag2_ff;
   logic [IdxW-1:0]             rank_ff;
   logic [lstm_pkg::VarW-1:0]   var_ff;
   logic [lstm_pkg::IntW-1:0]   rcnt_ff;
   logic [79:0]                 prod_ff;
   logic [1:0]                  mcnt_ff;

   logic        div_start, div_done;
   logic [63:0] div_a, div_q;
   logic [31:0] div_b, div_r;

   logic        accept, do_insert;
   logic [39:0] x, step, new_mean, mag2;
   logic [19:0] mul_a, mul_b;
   logic [39:0] pp;
   logic [79:0] pp_shift;
   logic [64:0] m2_sum;
   logic [lstm_pkg::CountW-1:0] n_next;
   logic [lstm_pkg::IntW-1:0] rcnt_next;
   logic        fire;

   lstm_pkg::entry_type entries [WORST_N];
   lstm_pkg::entry_type lefts   [WORST_N];
   logic                takes   [WORST_N];
   logic                ltakes  [WORST_N];

   assign csr.ready = (state_ff == S_IDLE);
   assign req.ready = (state_ff == S_IDLE) && !csr.valid;
   assign accept    = req.valid && req.ready;

   assign do_insert = (state_ff == S_M2) && div_done;

   for (genvar i = 0; i < WORST_N; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign lefts[i]  = '0;
         assign ltakes[i] = 1'b0;
      end else begin : g_body
         assign lefts[i]  = entries[i-1];
         assign ltakes[i] = takes[i-1];
      end
      lstm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .insert     (do_insert),
         .shift      (1'b0),
         .new_value  (v_ff),
         .new_tag    (tag_ff),
         .left_entry (lefts[i]),
         .left_takes (ltakes[i]),
         .entry      (entries[i]),
         .takes      (takes[i])
      );
   end

   assign x        = {v_ff, 16'd0};
   assign n_next   = (count_ff == '1) ? count_ff : count_ff + 32'd1;
   assign step     = div_q[39:0];
   assign new_mean = pos_ff ? mean_ff + step : mean_ff - step;
   assign mag2     = (x >= new_mean) ? x - new_mean : new_mean - x;
   assign mul_a    = mcnt_ff[1] ? mag_ff[39:20] : mag_ff[19:0];
   assign mul_b    = mcnt_ff[0] ? mag2_ff[39:20] : mag2_ff[19:0];
   assign pp       = mul_a * mul_b;
   assign m2_sum   = {1'b0, m2_ff} + {1'b0, prod_ff[79:16]};
   assign rcnt_next = (count_ff == '1) ? rcnt_ff :
                      (rcnt_ff + 16'd1 == interval_ff) ? 16'd0 : rcnt_ff + 16'd1;
   assign fire     = (interval_ff != '0) && (rcnt_next == '0);

   always_comb begin
      unique case (mcnt_ff)
         2'd0:       pp_shift = {40'd0, pp};
         2'd1, 2'd2: pp_shift = {20'd0, pp, 20'd0};
         2'd3:       pp_shift = {pp, 40'd0};
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      if (state_ff == S_MEAN) begin
         div_start = 1'b1;
         div_a     = {24'd0, mag_ff} + {33'd0, n_next[31:1]};
         div_b     = n_next;
      end else if (state_ff == S_CFG) begin
         div_start = 1'b1;
         div_a     = {32'd0, count_ff};
         div_b     = {16'd0, interval_ff};
      end else if (state_ff == S_VAR && rank_ff == '0 && !pos_ff) begin
         div_start = 1'b1;
         div_a     = m2_ff;
         div_b     = count_ff - 32'd1;
      end
   end

   lstm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   logic [48:0] var_round;
   assign var_round = {1'b0, div_q[63:16]} + {48'd0, div_q[15]};

   logic [IdxW-1:0] sel;
   assign sel = rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         interval_ff <= '0;
         count_ff    <= '0;
         mean_ff     <= '0;
         m2_ff       <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
         fill_ff     <= '0;
         reported_ff <= 1'b0;
         rcnt_ff     <= '0;
         rsp.valid   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (csr.valid) begin
                  interval_ff <= csr.data;
                  rcnt_ff     <= '0;
                  if (csr.data != '0) state_ff <= S_CFG;
               end else if (accept) begin
                  v_ff   <= req.sample_value;
                  tag_ff <= req.frame_tag;
                  rank_ff <= '0;
                  pos_ff <= 1'b0;
                  if (req.kind == lstm_pkg::KIND_FLUSH) begin
                     if (count_ff != '0 && !reported_ff && fill_ff != '0)
                        state_ff <= S_VAR;
                     reported_ff <= 1'b1;
                  end else begin
                     pos_ff   <= ({req.sample_value, 16'd0} >= mean_ff);
                     mag_ff   <= ({req.sample_value, 16'd0} >= mean_ff) ?
                                 {req.sample_value, 16'd0} - mean_ff :
                                 mean_ff - {req.sample_value, 16'd0};
                     state_ff <= S_MEAN;
                  end
               end
            end
            S_CFG: state_ff <= S_MOD;
            S_MOD: begin
               if (div_done) begin
                  rcnt_ff  <= lstm_pkg::IntW'(div_r);
                  state_ff <= S_IDLE;
               end
            end
            S_MEAN: state_ff <= S_M2;
            S_M2: begin
               if (div_done) begin
                  count_ff <= n_next;
                  mean_ff  <= new_mean;
                  mag2_ff  <= mag2;
                  prod_ff  <= '0;
                  mcnt_ff  <= '0;
                  if (count_ff == '0) begin
                     min_ff <= v_ff;
                     max_ff <= v_ff;
                  end else begin
                     if (v_ff < min_ff) min_ff <= v_ff;
                     if (v_ff > max_ff) max_ff <= v_ff;
                  end
                  if (fill_ff != FillW'(WORST_N)) fill_ff <= fill_ff + FillW'(1);
                  rcnt_ff     <= rcnt_next;
                  reported_ff <= fire;
                  state_ff    <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff <= prod_ff + pp_shift;
               mcnt_ff <= mcnt_ff + 2'd1;
               if (mcnt_ff == 2'd3) state_ff <= S_ACC;
            end
            S_ACC: begin
               m2_ff    <= m2_sum[64] ? '1 : m2_sum[63:0];
               pos_ff   <= 1'b0;
               state_ff <= reported_ff ? S_VAR : S_IDLE;
            end
            S_VAR: begin
               if (count_ff < 32'd2) begin
                  var_ff   <= '0;
                  state_ff <= S_EMIT;
               end else begin
                  pos_ff <= 1'b1;
                  if (div_done) begin
                     var_ff   <= var_round[48] ? '1 : var_round[47:0];
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (!rsp.valid) begin
                  rsp.valid          <= 1'b1;
                  rsp.sample_count   <= count_ff;
                  rsp.mean_value     <= (mean_ff[39:16] == '1 && mean_ff[15]) ? '1 :
                                        mean_ff[39:16] + {23'd0, mean_ff[15]};
                  rsp.variance_value <= var_ff;
                  rsp.min_value      <= min_ff;
                  rsp.max_value      <= max_ff;
                  rsp.worst_rank     <= lstm_pkg::RankW'(rank_ff);
                  rsp.worst_value    <= entries[sel].value;
                  rsp.worst_frame    <= entries[sel].tag;
                  rsp.last           <= (FillW'(rank_ff) + FillW'(1) == fill_ff);
               end else if (rsp.ready) begin
                  rsp.valid <= 1'b0;
                  if (rsp.last) begin
                     pos_ff   <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     rank_ff <= rank_ff + IdxW'(1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
